### sv/bdds_pkg.sv
// Shared constants, types and calendar helpers for the business-day date shifter.
`timescale 1ns / 1ps

package bdds_pkg;

    // Default widths of the year and the signed shift count
    localparam int YEAR_BITS_DEF  = 12;
    localparam int SHIFT_BITS_DEF = 16;

    // Fixed field widths
    localparam int MONTH_BITS = 4;
    localparam int DAY_BITS   = 5;
    localparam int WDAY_BITS  = 3;
    localparam int YDAY_BITS  = 9;

    // Input commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SHIFT = 1'b1;

    // Month codes
    localparam logic [MONTH_BITS-1:0] MONTH_JAN  = 4'd0;
    localparam logic [MONTH_BITS-1:0] MONTH_FEB  = 4'd1;
    localparam logic [MONTH_BITS-1:0] MONTH_DEC  = 4'd11;
    localparam logic [MONTH_BITS-1:0] NUM_MONTHS = 4'd12;

    // Weekday codes
    localparam logic [WDAY_BITS-1:0] WD_SUN = 3'd0;
    localparam logic [WDAY_BITS-1:0] WD_MON = 3'd1;
    localparam logic [WDAY_BITS-1:0] WD_THU = 3'd4;
    localparam logic [WDAY_BITS-1:0] WD_SAT = 3'd6;

    // Day constants
    localparam logic [DAY_BITS-1:0] DAY_FIRST = 5'd1;
    localparam logic [DAY_BITS-1:0] DAY_LONG  = 5'd31;
    localparam logic [DAY_BITS-1:0] FEB_SHORT = 5'd28;
    localparam logic [DAY_BITS-1:0] FEB_LEAP  = 5'd29;

    // Day-of-year of December 31 in a common year and in a leap year
    localparam logic [YDAY_BITS-1:0] YDAY_LAST_COMMON = 9'd364;
    localparam logic [YDAY_BITS-1:0] YDAY_LAST_LEAP   = 9'd365;

    // Reset date: Thursday, January 1, 1970
    localparam int unsigned RESET_YEAR = 70;

    // Stored year counts from this calendar year
    localparam int unsigned YEAR_BASE = 1900;

    // Divisibility by 25: multiply by the inverse of 25 mod 2^32 and
    // compare against the largest multiple quotient
    localparam logic [31:0] INV25     = 32'hC28F5C29;
    localparam logic [31:0] DIV25_MAX = 32'h0A3D70A3;

    // Month lengths of a common year, January first
    localparam logic [DAY_BITS-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Length of a month; codes past December count as 31-day months
    function automatic logic [DAY_BITS-1:0] days_in(
        input logic [MONTH_BITS-1:0] month,
        input logic                  leap
    );
        logic [DAY_BITS-1:0] len;
        if (month >= NUM_MONTHS) begin
            len = DAY_LONG;
        end else if (month == MONTH_FEB) begin
            len = leap ? FEB_LEAP : FEB_SHORT;
        end else begin
            len = MONTH_LEN[month];
        end
        return len;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic in_ready;   // input channel may take a beat
        logic accept;     // capture the input beat
        logic step;       // move one calendar day
        logic refresh;    // recompute the leap flag for the stored year
        logic out_write;  // copy the date into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_valid;    // input beat offered
        logic in_load;     // offered beat is a load
        logic in_zero;     // offered shift count is zero
        logic year_cross;  // the pending step crosses a year boundary
        logic step_last;   // the pending step reaches the last business day
        logic left_zero;   // no business days left to pass
        logic out_free;    // output register can take a result
    } t_dp_sts;

endpackage

### sv/bdds_in_if.sv
// Input channel of the date shifter: commands and load or shift payload.
`timescale 1ns / 1ps

interface bdds_in_if #(
    parameter int YEAR_BITS  = bdds_pkg::YEAR_BITS_DEF,
    parameter int SHIFT_BITS = bdds_pkg::SHIFT_BITS_DEF
);
    import bdds_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [YEAR_BITS-1:0]         load_year;
    logic [MONTH_BITS-1:0]        load_month;
    logic [DAY_BITS-1:0]          load_day;
    logic [WDAY_BITS-1:0]         load_weekday;
    logic [YDAY_BITS-1:0]         load_yearday;
    logic signed [SHIFT_BITS-1:0] day_shift;

    modport source (
        output valid, command, load_year, load_month, load_day,
               load_weekday, load_yearday, day_shift,
        input  ready
    );

    modport sink (
        input  valid, command, load_year, load_month, load_day,
               load_weekday, load_yearday, day_shift,
        output ready
    );

endinterface

### sv/bdds_out_if.sv
// Output channel of the date shifter: the resulting date and the wrap flag.
`timescale 1ns / 1ps

interface bdds_out_if #(
    parameter int YEAR_BITS = bdds_pkg::YEAR_BITS_DEF
);
    import bdds_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [YEAR_BITS-1:0]  year;
    logic [MONTH_BITS-1:0] month;
    logic [DAY_BITS-1:0]   day;
    logic [WDAY_BITS-1:0]  weekday;
    logic [YDAY_BITS-1:0]  yearday;
    logic                  year_wrapped;

    modport source (
        output valid, year, month, day, weekday, yearday, year_wrapped,
        input  ready
    );

    modport sink (
        input  valid, year, month, day, weekday, yearday, year_wrapped,
        output ready
    );

endinterface

### sv/bdds_ctrl.sv
// Sequencer of the date shifter: accept, day steps, leap refresh, result write.
`timescale 1ns / 1ps

module bdds_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdds_pkg::t_dp_sts i_sts,
    output bdds_pkg::t_dp_cmd o_cmd
);
    import bdds_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_STEP    = 4'b0010,
        ST_REFRESH = 4'b0100,
        ST_FINISH  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.in_load) begin
                        n_state = ST_REFRESH;
                    end else if (i_sts.in_zero) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
                // a new year needs its leap flag before the next step
                if (i_sts.year_cross) begin
                    n_state = ST_REFRESH;
                end else if (i_sts.step_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_REFRESH: begin
                o_cmd.refresh = 1'b1;
                n_state = i_sts.left_zero ? ST_FINISH : ST_STEP;
            end
            ST_FINISH: begin
                // hold until the previous result has been taken
                if (i_sts.out_free) begin
                    o_cmd.out_write = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/bdds_dp.sv
// Datapath of the date shifter: date registers, day step, leap unit, output register.
`timescale 1ns / 1ps

module bdds_dp #(
    parameter int YEAR_BITS  = bdds_pkg::YEAR_BITS_DEF,
    parameter int SHIFT_BITS = bdds_pkg::SHIFT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdds_pkg::t_dp_cmd i_cmd,
    output bdds_pkg::t_dp_sts o_sts,
    bdds_in_if.sink           i_in,
    bdds_out_if.source        o_out
);
    import bdds_pkg::*;

    // full calendar year needs one bit more than the larger of year and base
    localparam int FULL_BITS = ((YEAR_BITS > 11) ? YEAR_BITS : 11) + 1;

    // current date
    logic [YEAR_BITS-1:0]  r_year;
    logic [MONTH_BITS-1:0] r_month;
    logic [DAY_BITS-1:0]   r_day;
    logic [WDAY_BITS-1:0]  r_wday;
    logic [YDAY_BITS-1:0]  r_yday;
    logic                  r_leap;     // leap flag of r_year
    logic                  r_yday_fix; // Dec 31 entered backward, yearday awaits leap
    logic [SHIFT_BITS-1:0] r_left;     // business days still to pass
    logic                  r_back;     // shift runs backward
    logic                  r_wrapped;

    // output register
    logic                  r_out_valid;
    logic [YEAR_BITS-1:0]  r_out_year;
    logic [MONTH_BITS-1:0] r_out_month;
    logic [DAY_BITS-1:0]   r_out_day;
    logic [WDAY_BITS-1:0]  r_out_wday;
    logic [YDAY_BITS-1:0]  r_out_yday;
    logic                  r_out_wrapped;

    // next date after one step
    logic [YEAR_BITS-1:0]  n_year;
    logic [MONTH_BITS-1:0] n_month;
    logic [DAY_BITS-1:0]   n_day;
    logic [WDAY_BITS-1:0]  n_wday;
    logic [YDAY_BITS-1:0]  n_yday;

    logic [DAY_BITS-1:0]   w_dim;
    logic                  w_cross;
    logic                  w_wrap;
    logic                  w_business;
    logic                  w_neg;
    logic [SHIFT_BITS-1:0] w_mag;
    logic [FULL_BITS-1:0]  w_full;
    logic [31:0]           w_prod;
    logic                  w_leap;

    // leap unit: Gregorian rule on the full calendar year
    assign w_full = FULL_BITS'(r_year) + FULL_BITS'(YEAR_BASE);
    assign w_prod = 32'(w_full) * INV25;
    // leap = divisible by 4, and either not by 25 or also by 16
    assign w_leap = (w_full[1:0] == 2'b00) && ((w_prod > DIV25_MAX) || (w_full[3:0] == 4'b0000));

    // shift count magnitude
    assign w_neg = i_in.day_shift[SHIFT_BITS-1];
    assign w_mag = w_neg ? $unsigned(-i_in.day_shift) : $unsigned(i_in.day_shift);

    assign w_dim = days_in(r_month, r_leap);

    always_comb begin
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_yday  = r_yday;
        w_cross = 1'b0;
        w_wrap  = 1'b0;
        if (!r_back) begin
            if (r_wday == WD_SAT) begin
                n_wday = WD_SUN;
            end else if (r_wday > WD_SAT) begin
                n_wday = WD_MON;
            end else begin
                n_wday = r_wday + WDAY_BITS'(1);
            end
            if (r_day >= w_dim) begin
                n_day = DAY_FIRST;
                if (r_month >= MONTH_DEC) begin
                    w_cross = 1'b1;
                    w_wrap  = (r_year == {YEAR_BITS{1'b1}});
                    n_year  = r_year + YEAR_BITS'(1);
                    n_month = MONTH_JAN;
                    n_yday  = '0;
                end else begin
                    n_month = r_month + MONTH_BITS'(1);
                    n_yday  = r_yday + YDAY_BITS'(1);
                end
            end else begin
                n_day  = r_day + DAY_BITS'(1);
                n_yday = r_yday + YDAY_BITS'(1);
            end
        end else begin
            if (r_wday == WD_SUN || r_wday > WD_SAT) begin
                n_wday = WD_SAT;
            end else begin
                n_wday = r_wday - WDAY_BITS'(1);
            end
            if (r_day <= DAY_FIRST) begin
                if (r_month == MONTH_JAN) begin
                    w_cross = 1'b1;
                    w_wrap  = (r_year == '0);
                    n_year  = r_year - YEAR_BITS'(1);
                    n_month = MONTH_DEC;
                    n_day   = DAY_LONG;
                    // corrected by the leap refresh of the new year
                    n_yday  = YDAY_LAST_COMMON;
                end else begin
                    n_month = (r_month >= NUM_MONTHS) ? MONTH_DEC : r_month - MONTH_BITS'(1);
                    n_day   = days_in(n_month, r_leap);
                    n_yday  = r_yday - YDAY_BITS'(1);
                end
            end else begin
                n_day  = r_day - DAY_BITS'(1);
                n_yday = r_yday - YDAY_BITS'(1);
            end
        end
        w_business = (n_wday != WD_SUN) && (n_wday != WD_SAT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year      <= YEAR_BITS'(RESET_YEAR);
            r_month     <= MONTH_JAN;
            r_day       <= DAY_FIRST;
            r_wday      <= WD_THU;
            r_yday      <= '0;
            r_leap      <= 1'b0;
            r_yday_fix  <= 1'b0;
            r_left      <= '0;
            r_back      <= 1'b0;
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_wrapped <= 1'b0;
                if (i_in.command == CMD_LOAD) begin
                    r_year     <= i_in.load_year;
                    r_month    <= i_in.load_month;
                    r_day      <= i_in.load_day;
                    r_wday     <= i_in.load_weekday;
                    r_yday     <= i_in.load_yearday;
                    r_yday_fix <= 1'b0;
                    r_left     <= '0;
                end else begin
                    r_left <= w_mag;
                    r_back <= w_neg;
                end
            end
            if (i_cmd.step) begin
                r_year     <= n_year;
                r_month    <= n_month;
                r_day      <= n_day;
                r_wday     <= n_wday;
                r_yday     <= n_yday;
                r_yday_fix <= w_cross && r_back;
                if (w_business) begin
                    r_left <= r_left - SHIFT_BITS'(1);
                end
                if (w_wrap) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (i_cmd.refresh) begin
                r_leap     <= w_leap;
                r_yday_fix <= 1'b0;
                if (r_yday_fix) begin
                    r_yday <= w_leap ? YDAY_LAST_LEAP : YDAY_LAST_COMMON;
                end
            end
            if (i_cmd.out_write) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            r_out_year    <= r_year;
            r_out_month   <= r_month;
            r_out_day     <= r_day;
            r_out_wday    <= r_wday;
            r_out_yday    <= r_yday;
            r_out_wrapped <= r_wrapped;
        end
    end

    assign i_in.ready = i_cmd.in_ready;

    assign o_out.valid        = r_out_valid;
    assign o_out.year         = r_out_year;
    assign o_out.month        = r_out_month;
    assign o_out.day          = r_out_day;
    assign o_out.weekday      = r_out_wday;
    assign o_out.yearday      = r_out_yday;
    assign o_out.year_wrapped = r_out_wrapped;

    assign o_sts.in_valid   = i_in.valid;
    assign o_sts.in_load    = (i_in.command == CMD_LOAD);
    assign o_sts.in_zero    = (i_in.day_shift == '0);
    assign o_sts.year_cross = w_cross;
    assign o_sts.step_last  = w_business && (r_left == SHIFT_BITS'(1));
    assign o_sts.left_zero  = (r_left == '0);
    assign o_sts.out_free   = !r_out_valid || o_out.ready;

endmodule

### sv/business_day_date_shifter.sv
// Top level of the business-day date shifter.
`timescale 1ns / 1ps

// Keeps one calendar date (year since 1900, month, day, weekday, day of year).
// A load beat sets the date; a shift beat walks it one calendar day per
// clock, forward or backward, until the signed count of Monday-to-Friday days
// has been passed, stepping over weekends; at each year boundary crossed the
// walk pauses while the leap-year flag is recomputed. Each beat returns one
// result beat with the new date and a flag set when the year wrapped. Items
// are handled one at a time: a load passes through the leap refresh and the
// finish state to the result register; a shift walks about 1.4 calendar days
// per business day, one at a time through the single day-step datapath. A new
// beat is taken while the previous result still waits in the output register.
module business_day_date_shifter #(
    parameter int YEAR_BITS  = bdds_pkg::YEAR_BITS_DEF,
    parameter int SHIFT_BITS = bdds_pkg::SHIFT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdds_in_if.sink    i_in,
    bdds_out_if.source o_out
);
    import bdds_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    bdds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bdds_dp #(
        .YEAR_BITS  (YEAR_BITS),
        .SHIFT_BITS (SHIFT_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    // busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> !i_in.ready)
        else $error("input ready right after an accepted beat");

    // never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_write |-> sts.out_free)
        else $error("result register overwritten while still pending");

    // a day step only runs while business days remain
    a_step_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !sts.left_zero)
        else $error("day step with no business days left");

    // a loaded year gets its leap flag in the next cycle
    a_load_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && sts.in_load) |=> cmd.refresh)
        else $error("load not followed by leap refresh");

endmodule

### dv/tb_business_day_date_shifter.sv
// Self-checking testbench for the business-day date shifter: directed table, then random beats.
`timescale 1ns / 1ps

module tb_business_day_date_shifter;
    import bdds_pkg::*;

    localparam int YEAR_BITS  = YEAR_BITS_DEF;
    localparam int SHIFT_BITS = SHIFT_BITS_DEF;

    localparam int YEAR_TOP  = (1 << YEAR_BITS) - 1;
    localparam int SHIFT_MAX = (1 << (SHIFT_BITS - 1)) - 1;
    localparam int SHIFT_MIN = -(1 << (SHIFT_BITS - 1));
    localparam int YDAY_TOP  = (1 << YDAY_BITS) - 1;

    // Month and weekday codes the package does not name
    localparam logic [MONTH_BITS-1:0] MON_MAR       = 4'd2;
    localparam logic [MONTH_BITS-1:0] MON_APR       = 4'd3;
    localparam logic [MONTH_BITS-1:0] MON_JUN       = 4'd5;
    localparam logic [MONTH_BITS-1:0] MON_OVER_DEC  = 4'd13;
    localparam logic [MONTH_BITS-1:0] MON_OVER_DEC2 = 4'd14;
    localparam logic [MONTH_BITS-1:0] MON_TOP       = 4'd15;
    localparam logic [WDAY_BITS-1:0]  WD_WED        = 3'd3;
    localparam logic [WDAY_BITS-1:0]  WD_ALIAS      = 3'd7;

    localparam int RAND_ITEMS   = 900;
    localparam int QUIET_ITEMS  = 100;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 16;
    localparam int RUN_LIMIT_NS = 10_000_000;

    typedef struct packed {
        logic [YEAR_BITS-1:0]  year;
        logic [MONTH_BITS-1:0] month;
        logic [DAY_BITS-1:0]   day;
        logic [WDAY_BITS-1:0]  weekday;
        logic [YDAY_BITS-1:0]  yearday;
    } cal_date_t;

    typedef struct packed {
        cal_date_t date;
        logic      wrapped;
    } date_result_t;

    typedef struct packed {
        logic                         command;
        cal_date_t                    date;
        logic signed [SHIFT_BITS-1:0] days;
    } date_req_t;

    typedef struct packed {
        date_req_t    req;
        logic         typed;
        date_result_t want;
    } plan_row_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic sink_ready = 1'b0;
    int   sink_hold  = 0;
    logic stalls_on  = 1'b1;
    logic quiet      = 1'b0;

    cal_date_t    cal_now;
    date_result_t pending_dates [$];
    plan_row_t    date_plan [$];

    int n_loads   = 0;
    int n_shifts  = 0;
    int n_checked = 0;
    int n_bad     = 0;
    int n_wraps   = 0;

    bdds_in_if  #(.YEAR_BITS(YEAR_BITS), .SHIFT_BITS(SHIFT_BITS)) in_bus ();
    bdds_out_if #(.YEAR_BITS(YEAR_BITS)) out_bus ();

    assign out_bus.ready = sink_ready;

    business_day_date_shifter #(
        .YEAR_BITS (YEAR_BITS),
        .SHIFT_BITS(SHIFT_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d results still pending", pending_dates.size());
        $display("TB_ERROR");
        $finish;
    end

    // ---------------- calendar predictor ----------------

    function automatic bit leap_year(logic [YEAR_BITS-1:0] y);
        int unsigned full;
        full = YEAR_BASE + int'(y);
        return (full % 400 == 0) || ((full % 4 == 0) && (full % 100 != 0));
    endfunction

    function automatic logic [DAY_BITS-1:0] month_days(logic [MONTH_BITS-1:0] m,
                                                       logic [YEAR_BITS-1:0] y);
        logic [DAY_BITS-1:0] len;
        if (m >= NUM_MONTHS) begin
            len = DAY_LONG;
        end else if (m == MONTH_FEB) begin
            len = leap_year(y) ? FEB_LEAP : FEB_SHORT;
        end else begin
            len = MONTH_LEN[m];
        end
        return len;
    endfunction

    function automatic bit day_forward();
        bit wrap;
        wrap = 1'b0;
        cal_now.weekday = WDAY_BITS'((cal_now.weekday + 1) % 7);
        if (cal_now.day >= month_days(cal_now.month, cal_now.year)) begin
            if (cal_now.month >= MONTH_DEC) begin
                wrap            = (cal_now.year == YEAR_TOP);
                cal_now.year    = cal_now.year + 1'b1;
                cal_now.month   = MONTH_JAN;
                cal_now.day     = DAY_FIRST;
                cal_now.yearday = '0;
            end else begin
                cal_now.month   = cal_now.month + 1'b1;
                cal_now.day     = DAY_FIRST;
                cal_now.yearday = cal_now.yearday + 1'b1;
            end
        end else begin
            cal_now.day     = cal_now.day + 1'b1;
            cal_now.yearday = cal_now.yearday + 1'b1;
        end
        return wrap;
    endfunction

    function automatic bit day_backward();
        bit wrap;
        wrap = 1'b0;
        cal_now.weekday = WDAY_BITS'((cal_now.weekday + 6) % 7);
        if (cal_now.day <= DAY_FIRST) begin
            if (cal_now.month == MONTH_JAN) begin
                wrap            = (cal_now.year == 0);
                cal_now.year    = cal_now.year - 1'b1;
                cal_now.month   = MONTH_DEC;
                cal_now.day     = DAY_LONG;
                cal_now.yearday = leap_year(cal_now.year) ? YDAY_LAST_LEAP : YDAY_LAST_COMMON;
            end else begin
                // months past December fall back to December of the same year
                cal_now.month   = (cal_now.month >= NUM_MONTHS) ? MONTH_DEC
                                                                : cal_now.month - 1'b1;
                cal_now.day     = month_days(cal_now.month, cal_now.year);
                cal_now.yearday = cal_now.yearday - 1'b1;
            end
        end else begin
            cal_now.day     = cal_now.day - 1'b1;
            cal_now.yearday = cal_now.yearday - 1'b1;
        end
        return wrap;
    endfunction

    function automatic date_result_t advance_calendar(date_req_t rq);
        date_result_t res;
        int           n;
        int           passed;
        bit           wrap;
        wrap   = 1'b0;
        passed = 0;
        if (rq.command == CMD_LOAD) begin
            cal_now = rq.date;
        end else begin
            n = int'($signed(rq.days));
            while (passed < n) begin
                if (day_forward()) wrap = 1'b1;
                if (cal_now.weekday != WD_SUN && cal_now.weekday != WD_SAT) passed++;
            end
            while (passed > n) begin
                if (day_backward()) wrap = 1'b1;
                if (cal_now.weekday != WD_SUN && cal_now.weekday != WD_SAT) passed--;
            end
        end
        res.date    = cal_now;
        res.wrapped = wrap;
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic void plan_load(int y, int m, int d, int wd, int yd);
        plan_row_t r;
        r                  = '0;
        r.req.command      = CMD_LOAD;
        r.req.date.year    = YEAR_BITS'(y);
        r.req.date.month   = MONTH_BITS'(m);
        r.req.date.day     = DAY_BITS'(d);
        r.req.date.weekday = WDAY_BITS'(wd);
        r.req.date.yearday = YDAY_BITS'(yd);
        r.typed            = 1'b1;
        r.want.date        = r.req.date;
        date_plan.push_back(r);
    endfunction

    function automatic void plan_shift(int n);
        plan_row_t r;
        r             = '0;
        r.req.command = CMD_SHIFT;
        r.req.days    = SHIFT_BITS'(n);
        date_plan.push_back(r);
    endfunction

    function automatic void plan_shift_to(int n, int y, int m, int d, int wd, int yd,
                                          bit wrap);
        plan_row_t r;
        r                   = '0;
        r.req.command       = CMD_SHIFT;
        r.req.days          = SHIFT_BITS'(n);
        r.typed             = 1'b1;
        r.want.date.year    = YEAR_BITS'(y);
        r.want.date.month   = MONTH_BITS'(m);
        r.want.date.day     = DAY_BITS'(d);
        r.want.date.weekday = WDAY_BITS'(wd);
        r.want.date.yearday = YDAY_BITS'(yd);
        r.want.wrapped      = wrap;
        date_plan.push_back(r);
    endfunction

    function automatic int random_shift();
        int unsigned pick;
        int          mag;
        pick = $urandom_range(0, 99);
        if (pick < 3)       mag = 0;
        else if (pick < 72) mag = $urandom_range(1, 20);
        else if (pick < 94) mag = $urandom_range(21, 400);
        else                mag = $urandom_range(401, 1500);
        return ($urandom_range(0, 1) != 0) ? mag : -mag;
    endfunction

    // Well-formed date, biased toward month ends and both ends of the year range
    function automatic cal_date_t random_date();
        cal_date_t d;
        int        acc;
        case ($urandom_range(0, 4))
            0: begin
                d.year  = YEAR_BITS'($urandom_range(0, 2));
                d.month = ($urandom_range(0, 1) != 0) ? MONTH_JAN : MONTH_DEC;
            end
            1: begin
                d.year  = YEAR_BITS'(YEAR_TOP - $urandom_range(0, 2));
                d.month = ($urandom_range(0, 1) != 0) ? MONTH_JAN : MONTH_DEC;
            end
            2: begin
                d.year  = YEAR_BITS'($urandom_range(0, YEAR_TOP));
                d.month = MONTH_BITS'($urandom_range(0, NUM_MONTHS - 1));
            end
            default: begin
                d.year  = YEAR_BITS'($urandom_range(60, 200));
                d.month = MONTH_BITS'($urandom_range(0, NUM_MONTHS - 1));
            end
        endcase
        case ($urandom_range(0, 3))
            0:       d.day = DAY_FIRST;
            1:       d.day = month_days(d.month, d.year);
            default: d.day = DAY_BITS'($urandom_range(1, month_days(d.month, d.year)));
        endcase
        acc = d.day - 1;
        for (int k = 0; k < d.month; k++) acc += month_days(MONTH_BITS'(k), d.year);
        d.yearday = YDAY_BITS'(acc);
        d.weekday = WDAY_BITS'($urandom_range(0, 6));
        return d;
    endfunction

    function automatic cal_date_t raw_date();
        cal_date_t d;
        d.year    = YEAR_BITS'($urandom_range(0, YEAR_TOP));
        d.month   = MONTH_BITS'($urandom_range(0, MON_TOP));
        d.day     = DAY_BITS'($urandom_range(0, DAY_LONG));
        d.weekday = WDAY_BITS'($urandom_range(0, WD_ALIAS));
        d.yearday = YDAY_BITS'($urandom_range(0, YDAY_TOP));
        return d;
    endfunction

    task automatic send_date_beat(input date_req_t rq, input logic typed,
                                  input date_result_t typed_want);
        date_result_t want;
        in_bus.valid        <= 1'b1;
        in_bus.command      <= rq.command;
        in_bus.load_year    <= rq.date.year;
        in_bus.load_month   <= rq.date.month;
        in_bus.load_day     <= rq.date.day;
        in_bus.load_weekday <= rq.date.weekday;
        in_bus.load_yearday <= rq.date.yearday;
        in_bus.day_shift    <= rq.days;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        want = advance_calendar(rq);
        pending_dates.push_back(typed ? typed_want : want);
        if (rq.command == CMD_LOAD) n_loads++;
        else n_shifts++;
    endtask

    // Now and then drop valid for a burst of random length
    task automatic maybe_pause(input bit allow);
        if (allow && $urandom_range(0, 5) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // ---------------- result side ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
            sink_hold  <= 0;
        end else if (sink_hold != 0) begin
            sink_ready <= 1'b0;
            sink_hold  <= sink_hold - 1;
        end else if (stalls_on && !quiet && $urandom_range(0, 9) == 0) begin
            sink_ready <= 1'b0;
            sink_hold  <= $urandom_range(0, 10);
        end else begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        date_result_t got;
        date_result_t want;
        logic         bad;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.date.year    = out_bus.year;
            got.date.month   = out_bus.month;
            got.date.day     = out_bus.day;
            got.date.weekday = out_bus.weekday;
            got.date.yearday = out_bus.yearday;
            got.wrapped      = out_bus.year_wrapped;
            if (got.wrapped) n_wraps++;
            if (pending_dates.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("unexpected result beat: y=%0d m=%0d d=%0d wd=%0d yd=%0d wrap=%0d",
                             got.date.year, got.date.month, got.date.day,
                             got.date.weekday, got.date.yearday, got.wrapped);
            end else begin
                want = pending_dates.pop_front();
                n_checked++;
                bad = (got.date.year !== want.date.year)
                   || (got.date.month !== want.date.month)
                   || (got.date.day !== want.date.day)
                   || (got.date.weekday !== want.date.weekday)
                   || (got.date.yearday !== want.date.yearday)
                   || (got.wrapped !== want.wrapped);
                if (bad) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS) begin
                        $display("mismatch on result %0d at %0t", n_checked, $realtime);
                        $display("  expected y=%0d m=%0d d=%0d wd=%0d yd=%0d wrap=%0d",
                                 want.date.year, want.date.month, want.date.day,
                                 want.date.weekday, want.date.yearday, want.wrapped);
                        $display("  actual   y=%0d m=%0d d=%0d wd=%0d yd=%0d wrap=%0d",
                                 got.date.year, got.date.month, got.date.day,
                                 got.date.weekday, got.date.yearday, got.wrapped);
                    end
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        plan_row_t row;
        date_req_t rq;
        bit        calm;
        int        drain;

        in_bus.valid        <= 1'b0;
        in_bus.command      <= CMD_LOAD;
        in_bus.load_year    <= '0;
        in_bus.load_month   <= '0;
        in_bus.load_day     <= '0;
        in_bus.load_weekday <= '0;
        in_bus.load_yearday <= '0;
        in_bus.day_shift    <= '0;

        cal_now.year    = YEAR_BITS'(RESET_YEAR);
        cal_now.month   = MONTH_JAN;
        cal_now.day     = DAY_FIRST;
        cal_now.weekday = WD_THU;
        cal_now.yearday = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero shift returns the reset date; then step through the first weekend
        plan_shift_to(0, RESET_YEAR, MONTH_JAN, DAY_FIRST, WD_THU, 0, 1'b0);
        plan_shift(1);
        plan_shift(1);
        // top year wraps forward to zero, and back again
        plan_load(YEAR_TOP, MONTH_DEC, DAY_LONG, WD_SUN, YDAY_LAST_COMMON);
        plan_shift_to(1, 0, MONTH_JAN, DAY_FIRST, WD_MON, 0, 1'b1);
        plan_shift(-1);
        // back from March 1 into February of a common and a leap year
        plan_load(0, MON_MAR, DAY_FIRST, WD_THU, 59);
        plan_shift(-1);
        plan_load(100, MON_MAR, DAY_FIRST, WD_WED, 60);
        plan_shift(-1);
        // month codes past December
        plan_load(77, MON_OVER_DEC, DAY_LONG, WD_MON, 400);
        plan_shift(1);
        plan_load(77, MON_OVER_DEC2, DAY_FIRST, WD_MON, 400);
        plan_shift(-1);
        // day beyond the month end, and day zero
        plan_load(50, MON_APR, DAY_LONG, WD_MON, 119);
        plan_shift(1);
        plan_load(50, MON_APR, 0, WD_MON, 89);
        plan_shift(-1);
        // weekday seven and top yearday
        plan_load(120, MON_JUN, 15, WD_ALIAS, YDAY_TOP);
        plan_shift(1);
        // all-ones and all-zeros loads, then back across year zero
        plan_load(YEAR_TOP, MON_TOP, DAY_LONG, WD_ALIAS, YDAY_TOP);
        plan_load(0, MONTH_JAN, 0, WD_SUN, 0);
        plan_shift(-1);
        // largest counts both ways
        plan_load(123, MONTH_JAN, 15, WD_MON, 14);
        plan_shift(SHIFT_MAX);
        plan_shift(SHIFT_MIN);

        foreach (date_plan[k]) begin
            row = date_plan[k];
            send_date_beat(row.req, row.typed, row.want);
            maybe_pause(1'b1);
        end

        for (int i = 0; i < RAND_ITEMS; i++) begin
            calm       = (i >= RAND_ITEMS - QUIET_ITEMS);
            quiet     <= calm;
            stalls_on <= ((i / 70) % 3) != 2;
            rq         = '0;
            if ($urandom_range(0, 4) == 0) begin
                rq.command = CMD_LOAD;
                rq.date    = ($urandom_range(0, 3) == 0) ? raw_date() : random_date();
                rq.days    = SHIFT_BITS'($urandom_range(0, 16'hFFFF));
            end else begin
                rq.command = CMD_SHIFT;
                rq.date    = raw_date();
                rq.days    = SHIFT_BITS'(random_shift());
            end
            send_date_beat(rq, 1'b0, '0);
            maybe_pause(!calm && ((i / 45) % 4) != 3);
        end
        in_bus.valid <= 1'b0;

        drain = 0;
        while (pending_dates.size() != 0 && drain < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_dates.size() != 0) begin
            n_bad++;
            $display("%0d expected results never arrived", pending_dates.size());
        end

        $display("sent %0d loads and %0d shifts, checked %0d results, %0d failures",
                 n_loads, n_shifts, n_checked, n_bad);
        $display("results with the year-wrap flag set: %0d", n_wraps);
        if (n_bad == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### business_day_date_shifter.f
sv/bdds_pkg.sv
sv/bdds_in_if.sv
sv/bdds_out_if.sv
sv/bdds_ctrl.sv
sv/bdds_dp.sv
sv/business_day_date_shifter.sv
dv/tb_business_day_date_shifter.sv
